@@ hdl/arba_pkg.sv @@
// ----------------------------------------------------------------------------
// arba_pkg
// Shared constants and types for the converter ring buffer averager.
// ----------------------------------------------------------------------------
package arba_pkg;

   localparam int SAMPLE_W         = 8;
   localparam int CHAN_W           = 3;
   localparam int INPUT_LANES      = 4;
   localparam int DEFAULT_CHANNELS = 4;
   localparam int DEFAULT_DEPTH    = 8;
   localparam int DEFAULT_WINDOW   = 4;

   localparam logic OP_STORE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   typedef struct packed {
      logic shift_fwd;
      logic shift_back;
   } cell_ctrl_type;

endpackage

@@ hdl/arba_cell.sv @@
// ----------------------------------------------------------------------------
// arba_cell
// One ring slot: holds one byte per channel, shifts forward on store and
// backward while a read walks the ring.
// ----------------------------------------------------------------------------
module arba_cell #(
   parameter int CHANNELS = arba_pkg::DEFAULT_CHANNELS
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  arba_pkg::cell_ctrl_type                       ctrl,
   input  logic [CHANNELS-1:0][arba_pkg::SAMPLE_W-1:0]   prev_in,
   input  logic [CHANNELS-1:0][arba_pkg::SAMPLE_W-1:0]   next_in,
   output logic [CHANNELS-1:0][arba_pkg::SAMPLE_W-1:0]   data_out
);

   logic [CHANNELS-1:0][arba_pkg::SAMPLE_W-1:0] data_ff;
   logic [CHANNELS-1:0][arba_pkg::SAMPLE_W-1:0] data_in;

   always_comb begin
      priority if (ctrl.shift_fwd) begin
         data_in = prev_in;
      end else if (ctrl.shift_back) begin
         data_in = next_in;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= '0;
      end else begin
         data_ff <= data_in;
      end
   end

   assign data_out = data_ff;

endmodule

@@ hdl/arba_accum.sv @@
// ----------------------------------------------------------------------------
// arba_accum
// Window sum register with divide by the window length.
// ----------------------------------------------------------------------------
module arba_accum #(
   parameter int WINDOW = arba_pkg::DEFAULT_WINDOW
) (
   input  logic                          clock,
   input  logic                          clear,
   input  logic                          add,
   input  logic [arba_pkg::SAMPLE_W-1:0] sample,
   output logic [arba_pkg::SAMPLE_W-1:0] average
);

   localparam int SUM_W   = $clog2(WINDOW * ((1 << arba_pkg::SAMPLE_W) - 1) + 1);
   localparam int SHIFT   = SUM_W + $clog2(WINDOW);
   localparam int MULT_W  = SHIFT + 1;
   localparam int MULT    = ((1 << SHIFT) + WINDOW - 1) / WINDOW;
   localparam int PROD_W  = SUM_W + MULT_W;

   logic [SUM_W-1:0]  sum_ff;
   logic [SUM_W-1:0]  sum_in;
   logic [PROD_W-1:0] product;

   always_comb begin
      priority if (clear) begin
         sum_in = '0;
      end else if (add) begin
         sum_in = sum_ff + SUM_W'(sample);
      end else begin
         sum_in = sum_ff;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   // floor(sum / WINDOW) by reciprocal multiply, exact over the sum range
   assign product = PROD_W'(sum_ff) * PROD_W'(MULT_W'(MULT));
   assign average = product[SHIFT +: arba_pkg::SAMPLE_W];

endmodule

@@ hdl/adc_ring_buffer_averager_top.sv @@
// ----------------------------------------------------------------------------
// adc_ring_buffer_averager_top
// Per-channel ring of converter bytes with a moving average read-out.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on start while busy is low. A store item (opcode 0) shifts a
//   new sample set into the row of slot cells, gives no result
//   and leaves busy low, so stores may come every cycle.
//   A read item (opcode 1) names a channel. A channel at or above CHANNELS
//   gives rsp_channel_error = 1 and rsp_average = 0 in the next cycle.
//   A valid read rotates the cell row backward one slot per cycle, summing
//   the channel byte of the slots just before the newest, until the row is
//   back in place, then a done state forms the result. Busy stays high
//   until the result is out.
//   Each result is on the rsp_ ports for one cycle, marked by rsp_valid;
//   the receiver cannot stall.
//   Reset clears all slots to zero and returns the block to idle.
// ----------------------------------------------------------------------------
module adc_ring_buffer_averager_top #(
   parameter int CHANNELS = arba_pkg::DEFAULT_CHANNELS,
   parameter int DEPTH    = arba_pkg::DEFAULT_DEPTH,
   parameter int WINDOW   = arba_pkg::DEFAULT_WINDOW
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_opcode,
   input  logic [arba_pkg::SAMPLE_W-1:0] req_sample_a,
   input  logic [arba_pkg::SAMPLE_W-1:0] req_sample_b,
   input  logic [arba_pkg::SAMPLE_W-1:0] req_sample_c,
   input  logic [arba_pkg::SAMPLE_W-1:0] req_sample_d,
   input  logic [arba_pkg::CHAN_W-1:0]   req_channel,
   output logic                          rsp_valid,
   output logic [arba_pkg::SAMPLE_W-1:0] rsp_average,
   output logic                          rsp_channel_error
);

   localparam int ROT      = ((WINDOW + DEPTH - 1) / DEPTH) * DEPTH;
   localparam int CNT_W    = $clog2(ROT + 1);
   localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WALK = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [CH_IDX_W-1:0] chan_ff, chan_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [arba_pkg::SAMPLE_W-1:0] rsp_average_ff, rsp_average_in;
   logic                rsp_error_ff, rsp_error_in;

   logic                    accept;
   logic                    chan_ok;
   arba_pkg::cell_ctrl_type cell_ctrl;
   logic                    acc_clear, acc_add;
   logic [arba_pkg::SAMPLE_W-1:0] acc_sample, acc_average;

   logic [CHANNELS-1:0][arba_pkg::SAMPLE_W-1:0] new_set;
   logic [CHANNELS-1:0][arba_pkg::SAMPLE_W-1:0] cell_data [DEPTH];

   assign accept  = start && !busy;
   assign chan_ok = {1'b0, req_channel} < (arba_pkg::CHAN_W + 1)'(CHANNELS);

   // lanes without an input port are stored as zero
   always_comb begin
      new_set = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         unique case (c)
            0:       new_set[c] = req_sample_a;
            1:       new_set[c] = req_sample_b;
            2:       new_set[c] = req_sample_c;
            3:       new_set[c] = req_sample_d;
            default: new_set[c] = '0;
         endcase
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         arba_cell #(.CHANNELS(CHANNELS)) u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctrl     (cell_ctrl),
            .prev_in  (new_set),
            .next_in  (cell_data[(i + 1) % DEPTH]),
            .data_out (cell_data[i])
         );
      end else begin : g_body
         arba_cell #(.CHANNELS(CHANNELS)) u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctrl     (cell_ctrl),
            .prev_in  (cell_data[i - 1]),
            .next_in  (cell_data[(i + 1) % DEPTH]),
            .data_out (cell_data[i])
         );
      end
   end

   assign acc_sample = cell_data[1][chan_ff];

   arba_accum #(.WINDOW(WINDOW)) u_accum (
      .clock   (clock),
      .clear   (acc_clear),
      .add     (acc_add),
      .sample  (acc_sample),
      .average (acc_average)
   );

   always_comb begin
      state_in             = state_ff;
      cnt_in               = cnt_ff;
      chan_in              = chan_ff;
      rsp_valid_in         = 1'b0;
      rsp_average_in       = rsp_average_ff;
      rsp_error_in         = rsp_error_ff;
      cell_ctrl.shift_fwd  = 1'b0;
      cell_ctrl.shift_back = 1'b0;
      acc_clear            = 1'b0;
      acc_add              = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_opcode == arba_pkg::OP_STORE) begin
                  cell_ctrl.shift_fwd = 1'b1;
               end else if (!chan_ok) begin
                  rsp_valid_in   = 1'b1;
                  rsp_average_in = '0;
                  rsp_error_in   = 1'b1;
               end else begin
                  chan_in   = req_channel[CH_IDX_W-1:0];
                  cnt_in    = '0;
                  acc_clear = 1'b1;
                  state_in  = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            cell_ctrl.shift_back = 1'b1;
            acc_add              = cnt_ff < CNT_W'(WINDOW);
            cnt_in               = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(ROT - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            rsp_valid_in   = 1'b1;
            rsp_average_in = acc_average;
            rsp_error_in   = 1'b0;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chan_ff        <= chan_in;
      rsp_average_ff <= rsp_average_in;
      rsp_error_ff   <= rsp_error_in;
   end

   assign busy              = state_ff != ST_IDLE;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_average       = rsp_average_ff;
   assign rsp_channel_error = rsp_error_ff;

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the converter ring buffer averager against a behavioral predictor.
// Store and read items go in through start/busy with random gaps. Each read's
// expected average or channel error is queued when the item is taken, and
// every rsp_valid strobe is compared with the oldest entry.
// ----------------------------------------------------------------------------
module tb;

   localparam int SAMPLE_W         = arba_pkg::SAMPLE_W;
   localparam int CHAN_W           = arba_pkg::CHAN_W;
   localparam int DEFAULT_CHANNELS = arba_pkg::DEFAULT_CHANNELS;
   localparam int DEFAULT_DEPTH    = arba_pkg::DEFAULT_DEPTH;
   localparam int DEFAULT_WINDOW   = arba_pkg::DEFAULT_WINDOW;

   typedef struct {
      logic [SAMPLE_W-1:0] average;
      logic                channel_error;
   } mean_result_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic                req_opcode;
   logic [SAMPLE_W-1:0] req_sample_a;
   logic [SAMPLE_W-1:0] req_sample_b;
   logic [SAMPLE_W-1:0] req_sample_c;
   logic [SAMPLE_W-1:0] req_sample_d;
   logic [CHAN_W-1:0]   req_channel;
   logic                rsp_valid;
   logic [SAMPLE_W-1:0] rsp_average;
   logic                rsp_channel_error;

   logic [SAMPLE_W-1:0] model_ring [DEFAULT_CHANNELS][DEFAULT_DEPTH];
   int unsigned         model_slot;
   mean_result_type     awaited_means [$];
   int unsigned         mismatch_count;
   bit                  steady_flow;

   adc_ring_buffer_averager_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_sample_a      (req_sample_a),
      .req_sample_b      (req_sample_b),
      .req_sample_c      (req_sample_c),
      .req_sample_d      (req_sample_d),
      .req_channel       (req_channel),
      .rsp_valid         (rsp_valid),
      .rsp_average       (rsp_average),
      .rsp_channel_error (rsp_channel_error)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic mean_result_type window_mean(input logic [CHAN_W-1:0] ch);
      mean_result_type r;
      int unsigned     pos;
      int unsigned     total;
      pos   = model_slot;
      total = 0;
      if (ch >= DEFAULT_CHANNELS) begin
         r.average       = '0;
         r.channel_error = 1'b1;
         return r;
      end
      for (int k = 0; k < DEFAULT_WINDOW; k++) begin
         pos   = (pos == 0) ? DEFAULT_DEPTH - 1 : pos - 1;
         total += model_ring[ch][pos];
      end
      r.average       = SAMPLE_W'(total / DEFAULT_WINDOW);
      r.channel_error = 1'b0;
      return r;
   endfunction

   task automatic record_item(input logic op, input logic [SAMPLE_W-1:0] a,
                              input logic [SAMPLE_W-1:0] b,
                              input logic [SAMPLE_W-1:0] c,
                              input logic [SAMPLE_W-1:0] d,
                              input logic [CHAN_W-1:0] ch);
      if (op == arba_pkg::OP_STORE) begin
         model_slot = (model_slot >= DEFAULT_DEPTH - 1) ? 0 : model_slot + 1;
         model_ring[0][model_slot] = a;
         model_ring[1][model_slot] = b;
         model_ring[2][model_slot] = c;
         model_ring[3][model_slot] = d;
      end else begin
         awaited_means.push_back(window_mean(ch));
      end
   endtask

   task automatic send_item(input logic op, input logic [SAMPLE_W-1:0] a,
                            input logic [SAMPLE_W-1:0] b,
                            input logic [SAMPLE_W-1:0] c,
                            input logic [SAMPLE_W-1:0] d,
                            input logic [CHAN_W-1:0] ch);
      int unsigned gap;
      gap = steady_flow ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_opcode   <= op;
      req_sample_a <= a;
      req_sample_b <= b;
      req_sample_c <= c;
      req_sample_d <= d;
      req_channel  <= ch;
      start        <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      record_item(op, a, b, c, d, ch);
   endtask

   task automatic send_read(input logic [CHAN_W-1:0] ch);
      send_item(arba_pkg::OP_READ, SAMPLE_W'($urandom_range(0, 255)),
                SAMPLE_W'($urandom_range(0, 255)), SAMPLE_W'($urandom_range(0, 255)),
                SAMPLE_W'($urandom_range(0, 255)), ch);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (awaited_means.size() != 0);
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      mean_result_type want;
      if (!reset && rsp_valid !== 1'b0) begin
         if (rsp_valid !== 1'b1) begin
            report_mismatch("rsp_valid unknown", 0, 1);
         end else if (awaited_means.size() == 0) begin
            report_mismatch("result with no read pending", int'(rsp_average), -1);
         end else begin
            want = awaited_means.pop_front();
            if (rsp_average !== want.average)
               report_mismatch("average", int'(rsp_average), int'(want.average));
            if (rsp_channel_error !== want.channel_error)
               report_mismatch("channel_error", int'(rsp_channel_error),
                               int'(want.channel_error));
         end
      end
   end

   // empty ring: valid channels average to zero, upper channels flag
   task automatic test_reads_after_reset();
      for (int ch = 0; ch < 8; ch++) begin
         send_read(CHAN_W'(ch));
      end
   endtask

   task automatic test_field_extremes();
      repeat (5) send_item(arba_pkg::OP_STORE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd7);
      send_item(arba_pkg::OP_READ, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0);
      send_item(arba_pkg::OP_READ, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd3);
      repeat (4) send_item(arba_pkg::OP_STORE, 8'h00, 8'h00, 8'h00, 8'h00,
                           CHAN_W'($urandom_range(0, 7)));
      send_read(3'd1);
      send_item(arba_pkg::OP_READ, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd7);
   endtask

   task automatic test_drain_pause();
      repeat (3) send_read(CHAN_W'($urandom_range(0, 3)));
      wait_drained();
      send_read(3'd4);
   endtask

   function automatic logic [SAMPLE_W-1:0] draw_sample();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return SAMPLE_W'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic test_random_traffic(input int unsigned count);
      logic [CHAN_W-1:0] ch;
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0)
            steady_flow = ($urandom_range(0, 3) == 0);
         if (i % 100 == 99)
            wait_drained();
         ch = ($urandom_range(0, 9) < 8) ? CHAN_W'($urandom_range(0, 3))
                                         : CHAN_W'($urandom_range(4, 7));
         if ($urandom_range(0, 99) < 55)
            send_item(arba_pkg::OP_STORE, draw_sample(), draw_sample(), draw_sample(),
                      draw_sample(), CHAN_W'($urandom_range(0, 7)));
         else
            send_read(ch);
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      mismatch_count = 0;
      model_slot     = 0;
      steady_flow    = 1'b0;
      foreach (model_ring[c, s]) model_ring[c][s] = '0;
      reset        <= 1'b1;
      start        <= 1'b0;
      req_opcode   <= arba_pkg::OP_STORE;
      req_sample_a <= '0;
      req_sample_b <= '0;
      req_sample_c <= '0;
      req_sample_d <= '0;
      req_channel  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reads_after_reset();
      test_field_extremes();
      test_drain_pause();
      test_random_traffic(680);

      start <= 1'b0;
      while (awaited_means.size() != 0) @(posedge clock);
      repeat (24) @(posedge clock);
      if (mismatch_count == 0 && awaited_means.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
hdl/arba_pkg.sv
hdl/arba_cell.sv
hdl/arba_accum.sv
hdl/adc_ring_buffer_averager_top.sv
bench/tb.sv
